### rtl/core/thermadc_pkg.sv
// Shared types, constants and the NTC resistance table for the thermistor
// ADC-to-temperature converter. No dependencies.
package thermadc_pkg;

  localparam int AdcBits      = 12;
  localparam int TableEntries = 25;
  localparam int IdxW         = $clog2(TableEntries);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  localparam int TStep        = 5;
  localparam int TBase        = -40;
  localparam int TempW        = 9;
  localparam int CalcW        = TempW + 1;
  localparam logic [CalcW-1:0] ExtrapBase = CalcW'(TStep * (TableEntries - 1) + TBase);
  localparam logic [CalcW-1:0] InterpOfs  = CalcW'(-TBase);
  localparam int OhmsW        = 14;

  // Shared multiply/divide unit widths.
  localparam int McandW   = 16;
  localparam int MplierW  = 10;
  localparam int ProdW    = McandW + MplierW;
  localparam int DivisorW = 12;
  localparam int MulCntW  = $clog2(MplierW + 1);
  localparam int DivCntW  = $clog2(ProdW + 1);

  localparam logic [DivisorW-1:0] FullScale = DivisorW'((1 << AdcBits) - 1);

  // Status codes.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNoSensor = 2'd1;
  localparam logic [1:0] StAdcFail  = 2'd2;
  localparam logic [1:0] StDivider  = 2'd3;

  // Configuration register indexes.
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegScale    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegRefLevel = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegPullup   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegPulldown = CfgIdxW'(3);

  typedef struct packed {
    logic [AdcBits-1:0] sample_a;
    logic [AdcBits-1:0] sample_b;
    logic [AdcBits-1:0] sample_c;
    logic               sensor_present;
    logic               adc_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] temperature;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [McandW-1:0]   mcand;
    logic [MplierW-1:0]  mplier;
    logic [MulCntW-1:0]  mul_bits;
    logic [DivisorW-1:0] divisor;
    logic [DivCntW-1:0]  div_bits;
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] quot;
  } md_rsp_t;

  // Thermistor resistance in ohms at -40 C + 5 C * idx.
  function automatic logic [OhmsW-1:0] ntc_ohms(input logic [IdxW-1:0] idx);
    logic [OhmsW-1:0] val;
    case (idx)
      5'd0:    val = 14'd8430;
      5'd1:    val = 14'd6230;
      5'd2:    val = 14'd4660;
      5'd3:    val = 14'd3520;
      5'd4:    val = 14'd2690;
      5'd5:    val = 14'd2080;
      5'd6:    val = 14'd1610;
      5'd7:    val = 14'd1240;
      5'd8:    val = 14'd968;
      5'd9:    val = 14'd757;
      5'd10:   val = 14'd595;
      5'd11:   val = 14'd471;
      5'd12:   val = 14'd375;
      5'd13:   val = 14'd300;
      5'd14:   val = 14'd242;
      5'd15:   val = 14'd196;
      5'd16:   val = 14'd159;
      5'd17:   val = 14'd131;
      5'd18:   val = 14'd108;
      5'd19:   val = 14'd89;
      5'd20:   val = 14'd74;
      5'd21:   val = 14'd62;
      5'd22:   val = 14'd52;
      5'd23:   val = 14'd44;
      5'd24:   val = 14'd37;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/thermadc_muldiv.sv
// Bit-serial unit computing (mcand * mplier) / divisor, truncated.
// Shift-add multiply one multiplier bit per cycle, then restoring division
// one quotient bit per cycle. Depends on thermadc_pkg.
module thermadc_muldiv
  import thermadc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e           state_q, state_d;
  logic [ProdW-1:0]    acc_q, acc_d;
  logic [ProdW-1:0]    mcand_q, mcand_d;
  logic [MplierW-1:0]  mplier_q, mplier_d;
  logic [MulCntW-1:0]  mcnt_q, mcnt_d;
  logic [DivisorW-1:0] divisor_q, divisor_d;
  logic [DivCntW-1:0]  dcnt_q, dcnt_d;
  logic [DivisorW-1:0] rem_q, rem_d;
  logic [ProdW-1:0]    quot_q, quot_d;
  logic                done_q, done_d;
  logic [DivisorW+1:0] trial;

  assign trial = {1'b0, rem_q, acc_q[dcnt_q]} - {2'b00, divisor_q};

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    mcnt_d    = mcnt_q;
    divisor_d = divisor_q;
    dcnt_d    = dcnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    done_d    = 1'b0;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d     = '0;
          mcand_d   = ProdW'(req_i.mcand);
          mplier_d  = req_i.mplier;
          mcnt_d    = req_i.mul_bits - MulCntW'(1);
          divisor_d = req_i.divisor;
          dcnt_d    = req_i.div_bits - DivCntW'(1);
          rem_d     = '0;
          quot_d    = '0;
          state_d   = MD_MUL;
        end
      end
      MD_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[ProdW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MplierW-1:1]};
        if (mcnt_q == '0) begin
          state_d = MD_DIV;
        end else begin
          mcnt_d = mcnt_q - MulCntW'(1);
        end
      end
      MD_DIV: begin
        // Restoring step: keep the difference when it did not go negative.
        if (!trial[DivisorW+1]) begin
          rem_d  = trial[DivisorW-1:0];
          quot_d = {quot_q[ProdW-2:0], 1'b1};
        end else begin
          rem_d  = {rem_q[DivisorW-2:0], acc_q[dcnt_q]};
          quot_d = {quot_q[ProdW-2:0], 1'b0};
        end
        if (dcnt_q == '0) begin
          state_d = MD_IDLE;
          done_d  = 1'b1;
        end else begin
          dcnt_d = dcnt_q - DivCntW'(1);
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    mcand_q   <= mcand_d;
    mplier_q  <= mplier_d;
    mcnt_q    <= mcnt_d;
    divisor_q <= divisor_d;
    dcnt_q    <= dcnt_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### rtl/core/thermistor_adc_to_temperature.sv
// Thermistor ADC-to-temperature converter, top level; depends on thermadc_pkg, thermadc_muldiv.
// A missing sensor or ADC failure goes straight to the output state; a divider out of range is
// reported after the averaging and voltage-level passes through the bit-serial multiply/divide
// unit; a good item takes four passes through it plus a table search. One item at a time; busy
// stays high through the done_o cycle, and a new item is taken only in idle. The receiver cannot
// stall. Reset returns the configuration registers to their defaults and the sequencer to idle.
module thermistor_adc_to_temperature
  import thermadc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  in_item_t           item_i,
  output logic               done_o,
  output out_item_t          result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_AVG    = 7'b0000010,
    S_VLVL   = 7'b0000100,
    S_RES    = 7'b0001000,
    S_SRCH   = 7'b0010000,
    S_INTERP = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic                launch_q, launch_d;
  logic [AdcBits+1:0]  sum_q, sum_d;
  logic [AdcBits-1:0]  avg_q, avg_d;
  logic [9:0]          v_q, v_d;
  logic [9:0]          diff_q, diff_d;
  logic [15:0]         r_q, r_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  out_item_t           res_q, res_d;

  logic [9:0]          scale_q, ref_q;
  logic [15:0]         pullup_q, pulldown_q;

  md_req_t             md_req;
  md_rsp_t             md_rsp;

  logic [9:0]          v_new;
  logic                is_last;
  logic [IdxW-1:0]     idx_next;
  logic [OhmsW-1:0]    ohms_lo, ohms_hi;
  logic [CalcW-1:0]    q10, base10, temp10;

  // Configuration registers; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= 10'd376;
      ref_q      <= 10'd300;
      pullup_q   <= 16'd200;
      pulldown_q <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegScale:    scale_q    <= cfg_data_i[9:0];
        RegRefLevel: ref_q      <= cfg_data_i[9:0];
        RegPullup:   pullup_q   <= cfg_data_i;
        RegPulldown: pulldown_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  thermadc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign v_new    = md_rsp.quot[9:0];
  assign is_last  = (idx_q == LastIdx);
  assign idx_next = idx_q + IdxW'(1);
  assign ohms_lo  = is_last ? ntc_ohms(LastIdx) : ntc_ohms(idx_next);
  assign ohms_hi  = is_last ? ntc_ohms(LastIdx - IdxW'(1)) : ntc_ohms(idx_q);
  assign q10      = md_rsp.quot[CalcW-1:0];
  assign base10   = CalcW'(({{(CalcW-IdxW){1'b0}}, idx_q} + CalcW'(1)) * CalcW'(TStep));
  assign temp10   = is_last ? (q10 + ExtrapBase) : (base10 - q10 - InterpOfs);

  // Operands for the shared unit, sampled only while launch_q is high.
  always_comb begin
    md_req       = '0;
    md_req.start = launch_q;
    unique case (state_q)
      S_AVG: begin
        md_req.mcand    = McandW'(sum_q);
        md_req.mplier   = MplierW'(1);
        md_req.mul_bits = MulCntW'(1);
        md_req.divisor  = DivisorW'(3);
        md_req.div_bits = DivCntW'(AdcBits + 2);
      end
      S_VLVL: begin
        md_req.mcand    = McandW'(avg_q);
        md_req.mplier   = scale_q;
        md_req.mul_bits = MulCntW'(MplierW);
        md_req.divisor  = FullScale;
        md_req.div_bits = DivCntW'(AdcBits + MplierW);
      end
      S_RES: begin
        if (pullup_q != '0) begin
          md_req.mcand   = pullup_q;
          md_req.mplier  = v_q;
          md_req.divisor = DivisorW'(diff_q);
        end else begin
          md_req.mcand   = pulldown_q;
          md_req.mplier  = diff_q;
          md_req.divisor = DivisorW'(v_q);
        end
        md_req.mul_bits = MulCntW'(MplierW);
        md_req.div_bits = DivCntW'(ProdW);
      end
      S_INTERP: begin
        // Past the hottest entry the last segment is extended.
        md_req.mcand    = is_last ? (McandW'(ohms_lo) - r_q) : (r_q - McandW'(ohms_lo));
        md_req.mplier   = MplierW'(TStep);
        md_req.mul_bits = MulCntW'(3);
        md_req.divisor  = DivisorW'(ohms_hi - ohms_lo);
        md_req.div_bits = DivCntW'(19);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    sum_d    = sum_q;
    avg_d    = avg_q;
    v_d      = v_q;
    diff_d   = diff_q;
    r_d      = r_q;
    idx_d    = idx_q;
    res_d    = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d = '0;
          if (!item_i.sensor_present) begin
            res_d.status = StNoSensor;
            state_d      = S_OUT;
          end else if (!item_i.adc_ok) begin
            res_d.status = StAdcFail;
            state_d      = S_OUT;
          end else begin
            sum_d    = (AdcBits+2)'(item_i.sample_a) + (AdcBits+2)'(item_i.sample_b)
                     + (AdcBits+2)'(item_i.sample_c);
            launch_d = 1'b1;
            state_d  = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (md_rsp.done) begin
          avg_d    = md_rsp.quot[AdcBits-1:0];
          launch_d = 1'b1;
          state_d  = S_VLVL;
        end
      end
      S_VLVL: begin
        if (md_rsp.done) begin
          v_d    = v_new;
          diff_d = ref_q - v_new;
          if ((pullup_q != '0) ? (v_new >= ref_q) : ((v_new == '0) || (v_new > ref_q))) begin
            res_d.status = StDivider;
            state_d      = S_OUT;
          end else begin
            launch_d = 1'b1;
            state_d  = S_RES;
          end
        end
      end
      S_RES: begin
        if (md_rsp.done) begin
          r_d     = (md_rsp.quot[ProdW-1:16] != '0) ? 16'hFFFF : md_rsp.quot[15:0];
          idx_d   = '0;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (is_last || (r_q >= 16'(ntc_ohms(idx_next)))) begin
          launch_d = 1'b1;
          state_d  = S_INTERP;
        end else begin
          idx_d = idx_next;
        end
      end
      S_INTERP: begin
        if (md_rsp.done) begin
          res_d.temperature = temp10[TempW-1:0];
          res_d.status      = StOk;
          state_d           = S_OUT;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    avg_q  <= avg_d;
    v_q    <= v_d;
    diff_q <= diff_d;
    r_q    <= r_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = (state_q == S_OUT);
  assign result_o = res_q;

endmodule
